// ----- hw/rtl/fcr_pkg.sv -----
// Shared types, constants and the CRC byte step of the framed chunk receiver.
package fcr_pkg;

    localparam int MAX_CHUNK_LEN = 256;
    localparam int SIZE_BITS     = 24;
    localparam int HDR_BYTES     = 16;
    localparam int LEFT_W        = $clog2(MAX_CHUNK_LEN + 1);
    localparam int IDX_W         = $clog2(HDR_BYTES);
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_W         = 32;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Header magic "P2RF", first byte in lane 0.
    localparam logic [3:0][7:0] MAGIC = {8'h46, 8'h52, 8'h32, 8'h50};

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC  = 1'b1;

    typedef enum logic [1:0] {
        PH_FINISHED = 2'd0,
        PH_HEADER   = 2'd1,
        PH_PAYLOAD  = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        ST_BUSY      = 4'd0,
        ST_CHUNK_OK  = 4'd1,
        ST_DONE      = 4'd2,
        ST_MAGIC     = 4'd3,
        ST_SEQ       = 4'd4,
        ST_LEN       = 4'd5,
        ST_CRC_CHUNK = 4'd6,
        ST_CRC_TOTAL = 4'd7,
        ST_IGNORED   = 4'd8
    } t_status;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic                 payload_valid;
        logic [7:0]           payload_byte;
        t_status              status;
        logic [SIZE_BITS-1:0] chunk_sequence;
        logic [SIZE_BITS-1:0] bytes_received;
    } t_result;

    // Reflected CRC-32 update by one byte, bit steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fcr_in_if.sv -----
// Input channel: link beats carrying a function code and a byte.
interface fcr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ----- hw/rtl/fcr_out_if.sv -----
// Result channel: forwarded payload byte, status and progress counters.
interface fcr_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic [23:0] chunk_sequence;
    logic [23:0] bytes_received;

    modport source (output valid, output payload_valid, output payload_byte, output status,
                    output chunk_sequence, output bytes_received, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte, input status,
                    input chunk_sequence, input bytes_received, output ready);
endinterface

// ----- hw/rtl/fcr_in_stage.sv -----
// Input register stage that captures one link beat per cycle while not stalled.
module fcr_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcr_in_if.sink        i_in,
    input  logic          i_advance,
    output logic          o_valid,
    output fcr_pkg::t_item o_item
);

    logic           r_valid;
    fcr_pkg::t_item r_item;

    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.func      <= i_in.func;
            r_item.data_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/fcr_deframer.sv -----
// Deframing state: header parse, length and sequence checks, CRCs and counters.
module fcr_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  fcr_pkg::t_item                  i_item,
    input  logic [fcr_pkg::SIZE_BITS-1:0]   i_expected_size,
    input  logic [31:0]                     i_expected_crc,
    output fcr_pkg::t_result                o_result
);

    fcr_pkg::t_phase                r_phase,      n_phase;
    logic [fcr_pkg::IDX_W-1:0]      r_hdr_idx,    n_hdr_idx;
    logic                           r_magic_ok,   n_magic_ok;
    logic [31:0]                    r_hdr_seq,    n_hdr_seq;
    logic [31:0]                    r_hdr_len,    n_hdr_len;
    logic [31:0]                    r_hdr_crc,    n_hdr_crc;
    logic [fcr_pkg::LEFT_W-1:0]     r_left,       n_left;
    logic [fcr_pkg::SIZE_BITS-1:0]  r_next_seq,   n_next_seq;
    logic [fcr_pkg::SIZE_BITS-1:0]  r_received,   n_received;
    logic [31:0]                    r_crc_chunk,  n_crc_chunk;
    logic [31:0]                    r_crc_total,  n_crc_total;

    logic [31:0]                    crc_c;
    logic [31:0]                    crc_f;
    logic [fcr_pkg::SIZE_BITS-1:0]  bytes_open;
    fcr_pkg::t_status               status;
    logic                           pay_valid;
    logic [7:0]                     b;

    assign b     = i_item.data_byte;
    assign crc_c = fcr_pkg::crc_byte(r_crc_chunk, b);
    assign crc_f = fcr_pkg::crc_byte(r_crc_total, b);
    assign bytes_open = (i_expected_size > r_received) ? (i_expected_size - r_received)
                                                       : '0;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_magic_ok  = r_magic_ok;
        n_hdr_seq   = r_hdr_seq;
        n_hdr_len   = r_hdr_len;
        n_hdr_crc   = r_hdr_crc;
        n_left      = r_left;
        n_next_seq  = r_next_seq;
        n_received  = r_received;
        n_crc_chunk = r_crc_chunk;
        n_crc_total = r_crc_total;
        status      = fcr_pkg::ST_BUSY;
        pay_valid   = 1'b0;

        if (!i_item.func) begin
            // A start abandons whatever was in flight.
            n_phase     = fcr_pkg::PH_HEADER;
            n_hdr_idx   = '0;
            n_magic_ok  = 1'b1;
            n_hdr_seq   = '0;
            n_hdr_len   = '0;
            n_hdr_crc   = '0;
            n_left      = '0;
            n_next_seq  = '0;
            n_received  = '0;
            n_crc_chunk = fcr_pkg::CRC_INIT;
            n_crc_total = fcr_pkg::CRC_INIT;
            if (i_expected_size == '0) begin
                n_phase = fcr_pkg::PH_FINISHED;
                status  = (i_expected_crc == 32'd0) ? fcr_pkg::ST_DONE
                                                    : fcr_pkg::ST_CRC_TOTAL;
            end
        end else begin
            case (r_phase)
                fcr_pkg::PH_HEADER: begin
                    if (r_hdr_idx < fcr_pkg::IDX_W'(4)) begin
                        if (b != fcr_pkg::MAGIC[r_hdr_idx[1:0]]) begin
                            n_magic_ok = 1'b0;
                        end
                    end else if (r_hdr_idx < fcr_pkg::IDX_W'(8)) begin
                        n_hdr_seq = {b, r_hdr_seq[31:8]};
                    end else if (r_hdr_idx < fcr_pkg::IDX_W'(12)) begin
                        n_hdr_len = {b, r_hdr_len[31:8]};
                    end else begin
                        n_hdr_crc = {b, r_hdr_crc[31:8]};
                    end

                    if (r_hdr_idx != fcr_pkg::IDX_W'(fcr_pkg::HDR_BYTES - 1)) begin
                        n_hdr_idx = r_hdr_idx + 1'b1;
                    end else begin
                        // Last header byte: magic, sequence and length are complete.
                        n_hdr_idx = '0;
                        if (!r_magic_ok) begin
                            n_phase = fcr_pkg::PH_FINISHED;
                            status  = fcr_pkg::ST_MAGIC;
                        end else if (r_hdr_seq != 32'(r_next_seq)) begin
                            n_phase = fcr_pkg::PH_FINISHED;
                            status  = fcr_pkg::ST_SEQ;
                        end else if (r_hdr_len == 32'd0 ||
                                     r_hdr_len > 32'(fcr_pkg::MAX_CHUNK_LEN) ||
                                     r_hdr_len > 32'(bytes_open)) begin
                            n_phase = fcr_pkg::PH_FINISHED;
                            status  = fcr_pkg::ST_LEN;
                        end else begin
                            n_left      = r_hdr_len[fcr_pkg::LEFT_W-1:0];
                            n_crc_chunk = fcr_pkg::CRC_INIT;
                            n_phase     = fcr_pkg::PH_PAYLOAD;
                        end
                    end
                end

                fcr_pkg::PH_PAYLOAD: begin
                    pay_valid   = 1'b1;
                    n_crc_chunk = crc_c;
                    n_crc_total = crc_f;
                    if (r_left != '0) begin
                        n_left = r_left - 1'b1;
                    end
                    if (n_left == '0) begin
                        if ((crc_c ^ fcr_pkg::CRC_INIT) != r_hdr_crc) begin
                            n_phase = fcr_pkg::PH_FINISHED;
                            status  = fcr_pkg::ST_CRC_CHUNK;
                        end else begin
                            n_received = r_received +
                                fcr_pkg::SIZE_BITS'(r_hdr_len[fcr_pkg::LEFT_W-1:0]);
                            n_next_seq = r_next_seq + 1'b1;
                            n_magic_ok = 1'b1;
                            n_hdr_idx  = '0;
                            if (n_received >= i_expected_size) begin
                                n_phase = fcr_pkg::PH_FINISHED;
                                status  = ((crc_f ^ fcr_pkg::CRC_INIT) == i_expected_crc)
                                          ? fcr_pkg::ST_DONE : fcr_pkg::ST_CRC_TOTAL;
                            end else begin
                                n_phase = fcr_pkg::PH_HEADER;
                                status  = fcr_pkg::ST_CHUNK_OK;
                            end
                        end
                    end
                end

                default: begin
                    status = fcr_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fcr_pkg::PH_FINISHED;
            r_hdr_idx   <= '0;
            r_magic_ok  <= 1'b1;
            r_hdr_seq   <= '0;
            r_hdr_len   <= '0;
            r_hdr_crc   <= '0;
            r_left      <= '0;
            r_next_seq  <= '0;
            r_received  <= '0;
            r_crc_chunk <= fcr_pkg::CRC_INIT;
            r_crc_total <= fcr_pkg::CRC_INIT;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_magic_ok  <= n_magic_ok;
            r_hdr_seq   <= n_hdr_seq;
            r_hdr_len   <= n_hdr_len;
            r_hdr_crc   <= n_hdr_crc;
            r_left      <= n_left;
            r_next_seq  <= n_next_seq;
            r_received  <= n_received;
            r_crc_chunk <= n_crc_chunk;
            r_crc_total <= n_crc_total;
        end
    end

    assign o_result.payload_valid  = pay_valid;
    assign o_result.payload_byte   = pay_valid ? b : 8'd0;
    assign o_result.status         = status;
    assign o_result.chunk_sequence = n_next_seq;
    assign o_result.bytes_received = n_received;

`ifndef SYNTH
    // Any end status leaves the block finished until the next start.
    a_end_is_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && status != fcr_pkg::ST_BUSY && status != fcr_pkg::ST_CHUNK_OK)
        |=> (r_phase == fcr_pkg::PH_FINISHED))
        else $error("block not finished after an end status");

    // A chunk in progress always has payload bytes outstanding.
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fcr_pkg::PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    // Apart from a start, the committed byte count moves only when a chunk is verified.
    a_count_moves_on_verify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.func && status != fcr_pkg::ST_CHUNK_OK &&
         status != fcr_pkg::ST_DONE && status != fcr_pkg::ST_CRC_TOTAL)
        |=> $stable(r_received))
        else $error("received count changed without a verified chunk");

    // The header index only runs while a header is being parsed.
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fcr_pkg::PH_PAYLOAD) |-> (r_hdr_idx == '0))
        else $error("header index not cleared during payload");
`endif

endmodule

// ----- hw/rtl/framed_chunk_receiver_core.sv -----
// A beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; the CRC byte step, header checks and counter
// updates all sit in the single stage between the input and result registers.
// Back-pressure on the result channel stalls both registers together.
// Reset (synchronous, active low) empties both stages, zeroes the configuration
// registers and leaves the deframer finished, so link bytes report ignored.
module framed_chunk_receiver_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fcr_in_if.sink                          i_in,
    fcr_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fcr_pkg::CFG_W-1:0]       i_cfg_data
);

    logic [fcr_pkg::SIZE_BITS-1:0] r_expected_size;
    logic [31:0]                   r_expected_crc;

    logic             advance;
    logic             s_valid;
    logic             fire;
    fcr_pkg::t_item   s_item;
    fcr_pkg::t_result s_result;

    logic             r_out_valid;
    fcr_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= '0;
            r_expected_crc  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fcr_pkg::CFG_EXPECTED_SIZE: r_expected_size <= i_cfg_data[fcr_pkg::SIZE_BITS-1:0];
                fcr_pkg::CFG_EXPECTED_CRC:  r_expected_crc  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    // The result register frees up when empty or when its beat is taken.
    assign advance = !r_out_valid || o_out.ready;
    assign fire    = s_valid && advance;

    fcr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (s_valid),
        .o_item    (s_item)
    );

    fcr_deframer u_deframer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_item          (s_item),
        .i_expected_size (r_expected_size),
        .i_expected_crc  (r_expected_crc),
        .o_result        (s_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= s_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.payload_valid  = r_out.payload_valid;
    assign o_out.payload_byte   = r_out.payload_byte;
    assign o_out.status         = r_out.status;
    assign o_out.chunk_sequence = r_out.chunk_sequence;
    assign o_out.bytes_received = r_out.bytes_received;

endmodule
